### sv/shared_id_slot_table_top_macros.svh
// Assertion macros for the shared ID slot table.
`ifndef SHARED_ID_SLOT_TABLE_TOP_MACROS_SVH
`define SHARED_ID_SLOT_TABLE_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SIST_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SIST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/sist_pkg.sv
// Shared types and codes for the shared ID slot table.
package sist_pkg;

    localparam int CFG_BITS  = 32;
    localparam int UID_BITS  = 32;
    localparam int MODE_BITS = 3;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_INSERT       = 3'd0,
        MODE_FIND         = 3'd1,
        MODE_CLEAR_ONE    = 3'd2,
        MODE_CLEAR_ALL    = 3'd3,
        MODE_CLEAR_GUESTS = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_WB
    } t_state;

    // Controller to datapath commands.
    typedef struct packed {
        logic cap;  // capture request fields
        logic cmp;  // register compare vectors
        logic wb;   // write slots back, load result
    } t_cmd;

endpackage

### sv/sist_ctrl.sv
// Sequencer for capture, compare and write-back of each request.
module sist_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    output logic            o_valid,
    input  logic            i_ready,
    output sist_pkg::t_cmd  o_cmd
);

    sist_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic             wb_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sist_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        wb_go   = 1'b0;
        o_ready = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            sist_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_state = sist_pkg::S_CMP;
                end
            end
            sist_pkg::S_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = sist_pkg::S_WB;
            end
            sist_pkg::S_WB: begin
                wb_go = !r_out_valid || i_ready;
                if (wb_go) begin
                    o_cmd.wb = 1'b1;
                    o_ready  = 1'b1;
                    n_state  = i_valid ? sist_pkg::S_CMP : sist_pkg::S_IDLE;
                end
            end
            default: n_state = sist_pkg::S_IDLE;
        endcase
        o_cmd.cap = o_ready && i_valid;

        n_out_valid = r_out_valid;
        if (wb_go) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_valid = r_out_valid;

endmodule

### sv/sist_datapath.sv
// Slot registers, parallel compare, lowest-slot select and result register.
module sist_datapath #(
    parameter int NUM_SLOTS = 8,
    parameter int ID_BITS   = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sist_pkg::t_cmd                i_cmd,
    input  logic [sist_pkg::MODE_BITS-1:0] i_mode,
    input  logic [sist_pkg::UID_BITS-1:0]  i_user_id,
    input  logic                          i_cfg_we,
    input  logic [sist_pkg::CFG_BITS-1:0]  i_cfg_wdata,
    output logic                          o_ok
);

    logic [ID_BITS-1:0]     r_slot [NUM_SLOTS];
    logic [ID_BITS-1:0]     n_slot [NUM_SLOTS];
    logic [sist_pkg::CFG_BITS-1:0] r_owner;
    sist_pkg::t_mode        r_mode;
    logic [ID_BITS-1:0]     r_id;
    logic [ID_BITS-1:0]     id_ext;
    logic [ID_BITS-1:0]     owner_ext;
    logic [NUM_SLOTS-1:0]   r_hit, r_empty, r_keep;
    logic [NUM_SLOTS-1:0]   hit_first, empty_first;
    logic                   hit_any, empty_any;
    logic                   r_ok, n_ok;

    generate
        if (ID_BITS > sist_pkg::UID_BITS) begin : g_wide
            assign id_ext    = {{(ID_BITS-sist_pkg::UID_BITS){1'b0}}, i_user_id};
            assign owner_ext = {{(ID_BITS-sist_pkg::CFG_BITS){1'b0}}, r_owner};
        end else begin : g_narrow
            assign id_ext    = i_user_id[ID_BITS-1:0];
            assign owner_ext = r_owner[ID_BITS-1:0];
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owner <= '0;
        end else if (i_cfg_we) begin
            r_owner <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_mode <= sist_pkg::t_mode'(i_mode);
            r_id   <= id_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp) begin
            for (int k = 0; k < NUM_SLOTS; k++) begin
                r_hit[k]   <= (r_slot[k] == r_id);
                r_empty[k] <= (r_slot[k] == '0);
                r_keep[k]  <= (r_slot[k] == owner_ext);
            end
        end
    end

    // lowest set bit as one-hot
    assign hit_first   = r_hit & (~r_hit + NUM_SLOTS'(1));
    assign empty_first = r_empty & (~r_empty + NUM_SLOTS'(1));
    assign hit_any     = |r_hit;
    assign empty_any   = |r_empty;

    always_comb begin
        for (int k = 0; k < NUM_SLOTS; k++) begin
            n_slot[k] = r_slot[k];
        end
        n_ok = 1'b0;
        unique case (r_mode)
            sist_pkg::MODE_INSERT: begin
                n_ok = hit_any || empty_any;
                for (int k = 0; k < NUM_SLOTS; k++) begin
                    if (!hit_any && empty_first[k]) begin
                        n_slot[k] = r_id;
                    end
                end
            end
            sist_pkg::MODE_FIND: begin
                n_ok = hit_any;
            end
            sist_pkg::MODE_CLEAR_ONE: begin
                n_ok = hit_any;
                for (int k = 0; k < NUM_SLOTS; k++) begin
                    if (hit_first[k]) begin
                        n_slot[k] = '0;
                    end
                end
            end
            sist_pkg::MODE_CLEAR_ALL: begin
                n_ok = 1'b1;
                for (int k = 0; k < NUM_SLOTS; k++) begin
                    n_slot[k] = '0;
                end
            end
            sist_pkg::MODE_CLEAR_GUESTS: begin
                n_ok = 1'b1;
                for (int k = 0; k < NUM_SLOTS; k++) begin
                    if (!r_keep[k]) begin
                        n_slot[k] = '0;
                    end
                end
            end
            default: n_ok = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_SLOTS; k++) begin
                r_slot[k] <= '0;
            end
        end else if (i_cmd.wb) begin
            for (int k = 0; k < NUM_SLOTS; k++) begin
                r_slot[k] <= n_slot[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wb) begin
            r_ok <= n_ok;
        end
    end

    assign o_ok = r_ok;

endmodule

### sv/shared_id_slot_table_top.sv
// The result is valid once the request has been captured, compared and
//   written back; a new request can be accepted during the write-back of the
//   last one, and write-back waits while a finished result is still held at the output.
// Reset (synchronous, active low): all slots empty, owner ID zero,
//   no result pending; no clearing pass is needed.
// Top level of the shared ID slot table.
`include "shared_id_slot_table_top_macros.svh"

module shared_id_slot_table_top #(
    parameter int NUM_SLOTS = 8,
    parameter int ID_BITS   = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [sist_pkg::MODE_BITS-1:0] i_mode,
    input  logic [sist_pkg::UID_BITS-1:0]  i_user_id,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_ok,
    input  logic                           i_cfg_we,
    input  logic [sist_pkg::CFG_BITS-1:0]  i_cfg_wdata
);

    sist_pkg::t_cmd cmd;

    sist_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (cmd)
    );

    sist_datapath #(
        .NUM_SLOTS (NUM_SLOTS),
        .ID_BITS   (ID_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_mode      (i_mode),
        .i_user_id   (i_user_id),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_ok        (o_ok)
    );

    `SIST_ASSERT_NEXT(a_accept_cmp, i_clk, i_rst_n, i_valid && o_ready, cmd.cmp, "no compare after accept")
    `SIST_ASSERT_NEXT(a_cmp_wb, i_clk, i_rst_n, cmd.cmp, cmd.wb || o_valid, "write-back stalled with free output")
    `SIST_ASSERT_NEXT(a_wb_valid, i_clk, i_rst_n, cmd.wb, o_valid, "result not presented after write-back")
    `SIST_ASSERT_NOW(a_cmp_busy, i_clk, i_rst_n, cmd.cmp, !o_ready && !cmd.wb, "request taken during compare")

endmodule
